[design/keystroke_rate_monitor_unit_assert.svh]
`ifndef KEYSTROKE_RATE_MONITOR_UNIT_ASSERT_SVH
`define KEYSTROKE_RATE_MONITOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define KRM_CHECK(name, ck, rstn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define KRM_CHECK_NEXT(name, ck, rstn, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/krm_pkg.sv]
`timescale 1ns / 1ps

package krm_pkg;

  localparam int NUM_KEYS = 4;
  localparam int CNT_W    = 32;
  localparam int SUM_W    = 8;
  localparam int TMR_W    = 8;
  localparam int EDGE_W   = 3;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [TMR_W-1:0]  tmr_t;
  typedef logic [EDGE_W-1:0] edge_t;

  localparam tmr_t REST_RESET     = 8'd60;
  localparam sum_t RING_MAX_RESET = 8'd1;
  localparam logic [7:0] KEY_IDLE = 8'hFF;

  localparam logic OP_FRAME  = 1'b0;
  localparam logic OP_SECOND = 1'b1;

endpackage

[design/keystroke_rate_monitor_unit.sv]
// Frame tick: the request passes S_WIN and S_PEAK, then, while the display is
// active, the ring maximum scan, which reads the ring memory one entry per cycle,
// then S_TMR and S_DONE. Second tick: straight to S_DONE. One request is in work
// at a time; a finished result waits in the output register while the next
// request is accepted.
// Reset (rst_n, synchronous): sets all control state to its reset values at once;
// per-entry valid bits make both memories read as zero, so there is no clearing pass.
`timescale 1ns / 1ps
`include "keystroke_rate_monitor_unit_assert.svh"

module keystroke_rate_monitor_unit
  import krm_pkg::*;
#(
  parameter int WINDOW_LEN = 48,
  parameter int RING_DEPTH = 64,
  parameter int LANE_BITS  = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [7:0]           in_key_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CNT_W-1:0]     out_press_count_a,
  output logic [CNT_W-1:0]     out_press_count_b,
  output logic [CNT_W-1:0]     out_press_count_c,
  output logic [CNT_W-1:0]     out_press_count_d,
  output logic [LANE_BITS-1:0] out_lane_a,
  output logic [LANE_BITS-1:0] out_lane_b,
  output logic [LANE_BITS-1:0] out_lane_c,
  output logic [LANE_BITS-1:0] out_lane_d,
  output logic [SUM_W-1:0]     out_window_presses,
  output logic [SUM_W-1:0]     out_recent_peak,
  output logic [SUM_W-1:0]     out_history_peak,
  output logic                 out_display_active
);

  localparam int WA_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int RA_W = $clog2(RING_DEPTH);
  localparam int SC_W = $clog2(RING_DEPTH + 1);

  localparam logic [WA_W-1:0] WPOS_LAST = WA_W'(WINDOW_LEN - 1);
  localparam logic [RA_W-1:0] RPOS_LAST = RA_W'(RING_DEPTH - 1);
  localparam logic [SC_W-1:0] SCAN_END  = SC_W'(RING_DEPTH);
  localparam sum_t            SUM_MAX   = SUM_W'(NUM_KEYS * WINDOW_LEN);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_WIN  = 3'd1;
  localparam logic [2:0] S_PEAK = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_TMR  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]          state_r, state_nxt;
  logic [NUM_KEYS-1:0] prev_r, prev_nxt;
  cnt_t                cnt_r [NUM_KEYS];
  cnt_t                cnt_nxt [NUM_KEYS];
  logic [LANE_BITS-1:0] lane_r [NUM_KEYS];
  logic [LANE_BITS-1:0] lane_nxt [NUM_KEYS];
  logic [WA_W-1:0]     wpos_r, wpos_nxt;
  logic [RA_W-1:0]     rpos_r, rpos_nxt;
  sum_t                sum_r, sum_nxt;
  sum_t                peak_r, peak_nxt;
  sum_t                ring_max_r, ring_max_nxt;
  sum_t                acc_r, acc_nxt;
  tmr_t                dtimer_r, dtimer_nxt;
  tmr_t                rest_r, rest_nxt;
  edge_t               edges_r, edges_nxt;
  logic                act_r, act_nxt;
  logic [SC_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                in_acc;
  logic                out_load;
  logic [NUM_KEYS-1:0] held;
  edge_t               old_edges;
  sum_t                ring_rd;
  sum_t                acc_new;

  // window and ring memories
  edge_t               win_mem [WINDOW_LEN];
  edge_t               win_rdata_r;
  logic                win_rvld_r;
  logic [WINDOW_LEN-1:0] win_vld_r;
  logic                win_re, win_we;

  sum_t                ring_mem [RING_DEPTH];
  sum_t                ring_rdata_r;
  logic                ring_rvld_r;
  logic [RING_DEPTH-1:0] ring_vld_r;
  logic                ring_re, ring_we;

  // output register
  cnt_t                 o_cnt_r [NUM_KEYS];
  logic [LANE_BITS-1:0] o_lane_r [NUM_KEYS];
  sum_t                 o_sum_r, o_peak_r, o_hist_r;
  logic                 o_act_r;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign held     = ~in_key_byte[NUM_KEYS-1:0];

  assign win_re  = in_acc && (in_opcode == OP_FRAME);
  assign win_we  = (state_r == S_WIN);
  assign ring_we = in_acc && (in_opcode == OP_SECOND);
  assign ring_re = (state_r == S_SCAN) && (scan_cnt_r != SCAN_END);

  assign old_edges = win_rvld_r ? win_rdata_r : '0;
  assign ring_rd   = ring_rvld_r ? ring_rdata_r : '0;
  assign acc_new   = (pend_r && (ring_rd > acc_r)) ? ring_rd : acc_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    prev_nxt      = prev_r;
    cnt_nxt       = cnt_r;
    lane_nxt      = lane_r;
    wpos_nxt      = wpos_r;
    rpos_nxt      = rpos_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    ring_max_nxt  = ring_max_r;
    acc_nxt       = acc_r;
    dtimer_nxt    = dtimer_r;
    edges_nxt     = edges_r;
    act_nxt       = act_r;
    scan_cnt_nxt  = scan_cnt_r;
    pend_nxt      = pend_r;
    rest_nxt      = cfg_we ? cfg_wdata : rest_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_opcode == OP_FRAME) begin
            edges_nxt = '0;
            // key k sits on bit 3-k of the byte
            for (int k = 0; k < NUM_KEYS; k++) begin
              if (held[NUM_KEYS-1-k] && !prev_r[NUM_KEYS-1-k]) begin
                cnt_nxt[k] = cnt_r[k] + CNT_W'(1);
                edges_nxt  = edges_nxt + EDGE_W'(1);
              end
              lane_nxt[k] = {held[NUM_KEYS-1-k], lane_r[k][LANE_BITS-1:1]};
            end
            prev_nxt  = held;
            act_nxt   = (in_key_byte != KEY_IDLE);
            state_nxt = S_WIN;
          end else begin
            if (dtimer_r != '0) begin
              dtimer_nxt = dtimer_r - TMR_W'(1);
            end
            rpos_nxt  = (rpos_r == RPOS_LAST) ? '0 : rpos_r + RA_W'(1);
            peak_nxt  = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_WIN: begin
        // drop the overwritten entry, add the new one
        sum_nxt   = sum_r - SUM_W'(old_edges) + SUM_W'(edges_r);
        state_nxt = S_PEAK;
      end
      S_PEAK: begin
        if (sum_r > peak_r) begin
          peak_nxt = sum_r;
        end
        if (dtimer_r != '0) begin
          scan_cnt_nxt = '0;
          acc_nxt      = '0;
          pend_nxt     = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_TMR;
        end
      end
      S_SCAN: begin
        acc_nxt = acc_new;
        if (scan_cnt_r != SCAN_END) begin
          scan_cnt_nxt = scan_cnt_r + SC_W'(1);
          pend_nxt     = 1'b1;
        end else begin
          pend_nxt     = 1'b0;
          ring_max_nxt = acc_new;
          wpos_nxt     = (wpos_r == WPOS_LAST) ? '0 : wpos_r + WA_W'(1);
          state_nxt    = S_TMR;
        end
      end
      S_TMR: begin
        if ((ring_max_r != '0) || act_r) begin
          dtimer_nxt = rest_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prev_r      <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        cnt_r[k]  <= '0;
        lane_r[k] <= '0;
      end
      wpos_r      <= '0;
      rpos_r      <= '0;
      sum_r       <= '0;
      peak_r      <= '0;
      ring_max_r  <= RING_MAX_RESET;
      acc_r       <= '0;
      dtimer_r    <= REST_RESET;
      rest_r      <= REST_RESET;
      edges_r     <= '0;
      act_r       <= 1'b0;
      scan_cnt_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      cnt_r       <= cnt_nxt;
      lane_r      <= lane_nxt;
      wpos_r      <= wpos_nxt;
      rpos_r      <= rpos_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      ring_max_r  <= ring_max_nxt;
      acc_r       <= acc_nxt;
      dtimer_r    <= dtimer_nxt;
      rest_r      <= rest_nxt;
      edges_r     <= edges_nxt;
      act_r       <= act_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window memory: read at accept, written back in S_WIN while the read data is held
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[wpos_r] <= edges_r;
    end
    if (win_re) begin
      win_rdata_r <= win_mem[wpos_r];
      win_rvld_r  <= win_vld_r[wpos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_vld_r <= '0;
    end else if (win_we) begin
      win_vld_r[wpos_r] <= 1'b1;
    end
  end

  // ring memory: written on a second tick, swept during the scan
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[rpos_r] <= peak_r;
    end
    if (ring_re) begin
      ring_rdata_r <= ring_mem[scan_cnt_r[RA_W-1:0]];
      ring_rvld_r  <= ring_vld_r[scan_cnt_r[RA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_vld_r <= '0;
    end else if (ring_we) begin
      ring_vld_r[rpos_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_cnt_r  <= cnt_r;
      o_lane_r <= lane_r;
      o_sum_r  <= sum_r;
      o_peak_r <= peak_r;
      o_hist_r <= ring_max_r;
      o_act_r  <= (dtimer_r != '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_press_count_a  = o_cnt_r[0];
  assign out_press_count_b  = o_cnt_r[1];
  assign out_press_count_c  = o_cnt_r[2];
  assign out_press_count_d  = o_cnt_r[3];
  assign out_lane_a         = o_lane_r[0];
  assign out_lane_b         = o_lane_r[1];
  assign out_lane_c         = o_lane_r[2];
  assign out_lane_d         = o_lane_r[3];
  assign out_window_presses = o_sum_r;
  assign out_recent_peak    = o_peak_r;
  assign out_history_peak   = o_hist_r;
  assign out_display_active = o_act_r;

  `KRM_CHECK(a_sum_bound, clk, rst_n, 1'b1, sum_r <= SUM_MAX, "window sum out of range")
  `KRM_CHECK(a_scan_bound, clk, rst_n, state_r == S_SCAN, scan_cnt_r <= SCAN_END, "scan overrun")
  `KRM_CHECK(a_peak_cover, clk, rst_n, state_r == S_TMR, peak_r >= sum_r, "peak below sum")
  `KRM_CHECK_NEXT(a_reload, clk, rst_n, (state_r == S_TMR) && act_r, dtimer_r == $past(rest_r), "timer not reloaded")
  `KRM_CHECK_NEXT(a_peak_clear, clk, rst_n, ring_we, peak_r == '0, "peak not cleared")

endmodule

[dv/keystroke_rate_monitor_checker.sv]
`timescale 1ns / 1ps

module keystroke_rate_monitor_checker
  import krm_pkg::*;
#(
  parameter int WINDOW_LEN = 48,
  parameter int RING_DEPTH = 64,
  parameter int LANE_BITS  = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [7:0]           in_key_byte,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [CNT_W-1:0]     out_press_count_a,
  input  logic [CNT_W-1:0]     out_press_count_b,
  input  logic [CNT_W-1:0]     out_press_count_c,
  input  logic [CNT_W-1:0]     out_press_count_d,
  input  logic [LANE_BITS-1:0] out_lane_a,
  input  logic [LANE_BITS-1:0] out_lane_b,
  input  logic [LANE_BITS-1:0] out_lane_c,
  input  logic [LANE_BITS-1:0] out_lane_d,
  input  logic [SUM_W-1:0]     out_window_presses,
  input  logic [SUM_W-1:0]     out_recent_peak,
  input  logic [SUM_W-1:0]     out_history_peak,
  input  logic                 out_display_active,
  output int                   mismatches,
  output int                   outstanding
);

  typedef struct packed {
    cnt_t                 count_a;
    cnt_t                 count_b;
    cnt_t                 count_c;
    cnt_t                 count_d;
    logic [LANE_BITS-1:0] lane_a;
    logic [LANE_BITS-1:0] lane_b;
    logic [LANE_BITS-1:0] lane_c;
    logic [LANE_BITS-1:0] lane_d;
    sum_t                 window_total;
    sum_t                 peak;
    sum_t                 history;
    logic                 active;
  } monitor_snapshot_t;

  monitor_snapshot_t awaited_q[$];
  monitor_snapshot_t awaited;
  monitor_snapshot_t predicted;

  tmr_t                 rest_ticks;
  logic [3:0]           held_last;
  cnt_t                 presses [NUM_KEYS];
  logic [LANE_BITS-1:0] lanes [NUM_KEYS];
  edge_t                frame_rises [WINDOW_LEN];
  int                   frame_slot;
  sum_t                 peak_now;
  sum_t                 peak_ring [RING_DEPTH];
  int                   ring_slot;
  sum_t                 ring_peak;
  tmr_t                 active_timer;

  int fail_tally  = 0;
  int awaited_cnt = 0;

  assign mismatches  = fail_tally;
  assign outstanding = awaited_cnt;

  task automatic predict_snapshot(input logic op, input logic [7:0] kb,
                                  output monitor_snapshot_t snap);
    logic [3:0] held;
    int         rises;
    int         total;
    sum_t       ring_top;
    int         k;
    if (op == OP_FRAME) begin
      held  = ~kb[3:0];
      rises = 0;
      // key k sits on byte bit 3-k
      for (k = 0; k < NUM_KEYS; k++) begin
        if (held[3-k] && !held_last[3-k]) begin
          presses[k] = presses[k] + cnt_t'(1);
          rises++;
        end
        lanes[k] = {held[3-k], lanes[k][LANE_BITS-1:1]};
      end
      held_last              = held;
      frame_rises[frame_slot] = edge_t'(rises);
      total = 0;
      for (k = 0; k < WINDOW_LEN; k++) total += frame_rises[k];
      if (sum_t'(total) > peak_now) peak_now = sum_t'(total);
      // hold window slot and ring peak while the display is dark
      if (active_timer != 0) begin
        ring_top = '0;
        for (k = 0; k < RING_DEPTH; k++)
          if (peak_ring[k] > ring_top) ring_top = peak_ring[k];
        ring_peak  = ring_top;
        frame_slot = (frame_slot + 1) % WINDOW_LEN;
      end
      if (ring_peak != 0 || kb != KEY_IDLE) active_timer = rest_ticks;
    end else begin
      if (active_timer != 0) active_timer = active_timer - tmr_t'(1);
      peak_ring[ring_slot] = peak_now;
      ring_slot            = (ring_slot + 1) % RING_DEPTH;
      peak_now             = '0;
    end
    total = 0;
    for (k = 0; k < WINDOW_LEN; k++) total += frame_rises[k];
    snap.count_a      = presses[0];
    snap.count_b      = presses[1];
    snap.count_c      = presses[2];
    snap.count_d      = presses[3];
    snap.lane_a       = lanes[0];
    snap.lane_b       = lanes[1];
    snap.lane_c       = lanes[2];
    snap.lane_d       = lanes[3];
    snap.window_total = sum_t'(total);
    snap.peak         = peak_now;
    snap.history      = ring_peak;
    snap.active       = (active_timer != 0);
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rest_ticks   = REST_RESET;
      held_last    = '0;
      frame_slot   = 0;
      peak_now     = '0;
      ring_slot    = 0;
      ring_peak    = RING_MAX_RESET;
      active_timer = REST_RESET;
      for (int k = 0; k < NUM_KEYS; k++) begin
        presses[k] = '0;
        lanes[k]   = '0;
      end
      for (int k = 0; k < WINDOW_LEN; k++) frame_rises[k] = '0;
      for (int k = 0; k < RING_DEPTH; k++) peak_ring[k] = '0;
      awaited_q.delete();
    end else begin
      if (cfg_we) rest_ticks = cfg_wdata;
      if (in_valid && !in_stall) begin
        predict_snapshot(in_opcode, in_key_byte, predicted);
        awaited_q.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          $error("result arrived with no request in flight");
          fail_tally++;
        end else begin
          awaited = awaited_q.pop_front();
          compare_field("press_count_a", awaited.count_a, out_press_count_a);
          compare_field("press_count_b", awaited.count_b, out_press_count_b);
          compare_field("press_count_c", awaited.count_c, out_press_count_c);
          compare_field("press_count_d", awaited.count_d, out_press_count_d);
          compare_field("lane_a", awaited.lane_a, out_lane_a);
          compare_field("lane_b", awaited.lane_b, out_lane_b);
          compare_field("lane_c", awaited.lane_c, out_lane_c);
          compare_field("lane_d", awaited.lane_d, out_lane_d);
          compare_field("window_presses", awaited.window_total, out_window_presses);
          compare_field("recent_peak", awaited.peak, out_recent_peak);
          compare_field("history_peak", awaited.history, out_history_peak);
          compare_field("display_active", awaited.active, out_display_active);
        end
      end
    end
    awaited_cnt <= awaited_q.size();
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import krm_pkg::*;

  localparam int LANE_W     = 64;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE     = 80;
  localparam int PHASES     = 7;
  localparam int PHASE_LEN  = 55;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       cfg_we      = 1'b0;
  logic [7:0] cfg_wdata   = 8'd0;
  logic       in_valid    = 1'b0;
  logic       in_opcode   = OP_FRAME;
  logic [7:0] in_key_byte = KEY_IDLE;
  logic       out_stall   = 1'b0;

  logic              in_stall;
  logic              out_valid;
  cnt_t              out_press_count_a, out_press_count_b;
  cnt_t              out_press_count_c, out_press_count_d;
  logic [LANE_W-1:0] out_lane_a, out_lane_b, out_lane_c, out_lane_d;
  sum_t              out_window_presses, out_recent_peak, out_history_peak;
  logic              out_display_active;

  int         mismatches;
  int         outstanding;
  int         idle_cycles     = 0;
  bit         sender_pauses   = 1'b1;
  bit         receiver_pauses = 1'b1;
  bit         long_hold_req   = 1'b0;
  logic [3:0] key_nibble      = 4'hF;

  always #4 clk = ~clk;

  keystroke_rate_monitor_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_key_byte        (in_key_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_press_count_a  (out_press_count_a),
    .out_press_count_b  (out_press_count_b),
    .out_press_count_c  (out_press_count_c),
    .out_press_count_d  (out_press_count_d),
    .out_lane_a         (out_lane_a),
    .out_lane_b         (out_lane_b),
    .out_lane_c         (out_lane_c),
    .out_lane_d         (out_lane_d),
    .out_window_presses (out_window_presses),
    .out_recent_peak    (out_recent_peak),
    .out_history_peak   (out_history_peak),
    .out_display_active (out_display_active)
  );

  keystroke_rate_monitor_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_key_byte        (in_key_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_press_count_a  (out_press_count_a),
    .out_press_count_b  (out_press_count_b),
    .out_press_count_c  (out_press_count_c),
    .out_press_count_d  (out_press_count_d),
    .out_lane_a         (out_lane_a),
    .out_lane_b         (out_lane_b),
    .out_lane_c         (out_lane_c),
    .out_lane_d         (out_lane_d),
    .out_window_presses (out_window_presses),
    .out_recent_peak    (out_recent_peak),
    .out_history_peak   (out_history_peak),
    .out_display_active (out_display_active),
    .mismatches         (mismatches),
    .outstanding        (outstanding)
  );

  // Offer one request; returns at the edge that accepts it, valid still high.
  task automatic send_request(input logic op, input logic [7:0] kb);
    int gap;
    gap = sender_pauses ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_key_byte <= kb;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_frame(input logic [7:0] kb);
    send_request(OP_FRAME, kb);
  endtask

  task automatic send_second();
    send_request(OP_SECOND, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_rest(input tmr_t value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly keys that come and go a few at a time, plus raw bytes, idle frames and second ticks.
  task automatic random_request();
    int         pick;
    logic [7:0] kb;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_second();
    end else if (pick < 16) begin
      repeat ($urandom_range(2, 6)) send_second();
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        key_nibble = key_nibble ^ (4'($urandom) & 4'($urandom));
        kb = {4'hF, key_nibble};
        if ($urandom_range(0, 9) == 0) kb[7:4] = 4'($urandom);
      end else if (pick < 90) begin
        kb = 8'($urandom);
      end else begin
        kb = KEY_IDLE;
      end
      send_frame(kb);
    end
  endtask

  // Result side: random hold-offs, plus one long hold when asked.
  initial begin
    int hold;
    forever begin
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end
      hold = receiver_pauses ? $urandom_range(0, 10) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
      idle_cycles++;
    else
      idle_cycles = 0;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    tmr_t rest_plan [PHASES];
    rest_plan = '{8'd1, 8'd255, 8'd0, REST_RESET, 8'd2, 8'd0, 8'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Dark display: rest of zero blanks the timer on the first activity.
    write_rest(8'd0);
    send_frame(KEY_IDLE);
    send_frame(8'hF0);
    send_frame(KEY_IDLE);
    send_frame(8'h00);
    send_second();
    send_frame(8'h0F);

    // Wake from dark on upper-bit activity, then each key alone.
    write_rest(8'd255);
    send_frame(8'h7F);
    send_frame(8'hF7);
    send_frame(8'hFB);
    send_frame(8'hFD);
    send_frame(8'hFE);
    send_frame(8'h80);
    send_frame(8'h00);
    send_second();
    send_second();
    send_frame(KEY_IDLE);

    // Timer runs out with a nonzero ring peak.
    write_rest(8'd1);
    send_frame(8'hF5);
    send_second();
    send_frame(KEY_IDLE);
    send_second();
    send_second();
    send_frame(8'hAA);
    send_frame(8'h55);

    for (int p = 0; p < PHASES; p++) begin
      if (p >= 5) rest_plan[p] = 8'($urandom);
      write_rest(rest_plan[p]);
      sender_pauses   = (p % 3 != 1);
      receiver_pauses = (p % 3 != 2);
      for (int n = 0; n < PHASE_LEN; n++) begin
        if (p == 3 && n == 20) long_hold_req = 1'b1;
        if (p == 4 && n == 30) drain();
        random_request();
      end
    end

    // Quiet stretch: empty the window and the ring so the ring peak drops to zero.
    sender_pauses   = 1'b1;
    receiver_pauses = 1'b1;
    write_rest(8'd3);
    repeat (48) send_frame(KEY_IDLE);
    repeat (66) send_second();
    repeat (16) send_frame(KEY_IDLE);
    repeat (4) send_second();
    repeat (5) send_frame(KEY_IDLE);

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
